/* src/tlpb_pkg.sv */
// ----------------------------------------------------------------------------
// tlpb_pkg
// Types and constants shared by the three-layer pixel blender.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpb_pkg;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WEIGHT_FIRST  = 2'd0,
    REG_WEIGHT_SECOND = 2'd1,
    REG_WEIGHT_THIRD  = 2'd2,
    REG_BLEND_MODE    = 2'd3
  } reg_idx_t;

  // modes 5..7 fall into the darkest arm
  typedef enum logic [2:0] {
    MODE_SUM   = 3'd0,
    MODE_DIFF  = 3'd1,
    MODE_XFADE = 3'd2,
    MODE_LIGHT = 3'd3,
    MODE_DARK  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [6:0] weight_first;
    logic [6:0] weight_second;
    logic [6:0] weight_third;
    logic [2:0] blend_mode;
  } cfg_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  localparam logic [6:0]        PERCENT_HALF = 7'd50;
  localparam logic signed [9:0] COEF_FULL    = 10'sd100;
  localparam logic signed [9:0] COEF_DOUBLE  = 10'sd200;

  // V / 100 for V < 25600: (V * 5243) >> 19 is exact well beyond that
  localparam logic [16:0] SAT_LIMIT   = 17'd25600;
  localparam logic [12:0] RECIP       = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [7:0]  CHANNEL_MAX = 8'd255;

endpackage

`default_nettype wire

/* src/tlpb_prod.sv */
// ----------------------------------------------------------------------------
// tlpb_prod
// Stage 1: weighted terms of one channel and the two crossfade products.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpb_prod (
  input  wire logic              clk,
  input  wire tlpb_pkg::pipe_en_t en,
  input  wire tlpb_pkg::cfg_t     cfg,
  input  wire logic [7:0]        p1,
  input  wire logic [7:0]        p2,
  input  wire logic [7:0]        p3,
  output logic [14:0]            t1_r,
  output logic [14:0]            t2_r,
  output logic [14:0]            t3_r,
  output logic signed [17:0]     xa_r,
  output logic signed [17:0]     xb_r
);

  logic               lo_half;
  logic signed [9:0]  two_w1;
  logic signed [9:0]  coef_a;
  logic signed [9:0]  coef_b;
  logic [7:0]         pix_b;
  logic signed [19:0] prod_a;
  logic signed [19:0] prod_b;

  // below half: fade layer one -> two; otherwise layer two -> three
  always_comb begin
    lo_half = cfg.weight_first < tlpb_pkg::PERCENT_HALF;
    two_w1  = $signed({2'b00, cfg.weight_first, 1'b0});
    if (lo_half) begin
      coef_a = two_w1;
      coef_b = tlpb_pkg::COEF_FULL - two_w1;
      pix_b  = p1;
    end else begin
      coef_a = tlpb_pkg::COEF_DOUBLE - two_w1;
      coef_b = two_w1 - tlpb_pkg::COEF_FULL;
      pix_b  = p3;
    end
    prod_a = coef_a * $signed({2'b00, p2});
    prod_b = coef_b * $signed({2'b00, pix_b});
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      t1_r <= cfg.weight_first * p1;
      t2_r <= cfg.weight_second * p2;
      t3_r <= cfg.weight_third * p3;
      xa_r <= prod_a[17:0];
      xb_r <= prod_b[17:0];
    end
  end

endmodule

`default_nettype wire

/* src/tlpb_mix.sv */
// ----------------------------------------------------------------------------
// tlpb_mix
// Stage 2: mixes weighted terms by mode; |diff| taken, xfade clamped at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpb_mix (
  input  wire logic              clk,
  input  wire tlpb_pkg::pipe_en_t en,
  input  wire logic [2:0]        blend_mode,
  input  wire logic [14:0]       t1,
  input  wire logic [14:0]       t2,
  input  wire logic [14:0]       t3,
  input  wire logic signed [17:0] xa,
  input  wire logic signed [17:0] xb,
  output logic [16:0]            v_r
);

  logic [16:0]        sum_v;
  logic signed [17:0] diff_s;
  logic [16:0]        diff_v;
  logic signed [17:0] xf_s;
  logic [16:0]        xf_v;
  logic [14:0]        max12;
  logic [14:0]        max_v;
  logic [14:0]        min12;
  logic [14:0]        min_v;
  logic [16:0]        v_nxt;

  always_comb begin
    sum_v  = {2'b00, t1} + {2'b00, t2} + {2'b00, t3};
    diff_s = $signed({3'b000, t1}) - $signed({3'b000, t2}) - $signed({3'b000, t3});
    diff_v = diff_s[17] ? 17'(-diff_s) : diff_s[16:0];
    xf_s   = xa + xb;
    xf_v   = xf_s[17] ? 17'd0 : xf_s[16:0];
    max12  = (t1 > t2) ? t1 : t2;
    max_v  = (t3 > max12) ? t3 : max12;
    min12  = (t1 < t2) ? t1 : t2;
    min_v  = (t3 < min12) ? t3 : min12;
    case (blend_mode)
      tlpb_pkg::MODE_SUM:   v_nxt = sum_v;
      tlpb_pkg::MODE_DIFF:  v_nxt = diff_v;
      tlpb_pkg::MODE_XFADE: v_nxt = xf_v;
      tlpb_pkg::MODE_LIGHT: v_nxt = {2'b00, max_v};
      default:              v_nxt = {2'b00, min_v};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      v_r <= v_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/tlpb_scale.sv */
// ----------------------------------------------------------------------------
// tlpb_scale
// Stages 3 and 4: divide by 100 through a reciprocal, saturate at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpb_scale (
  input  wire logic              clk,
  input  wire tlpb_pkg::pipe_en_t en,
  input  wire logic [16:0]       v,
  output logic [7:0]             q_r
);

  logic        sat_r;
  logic [27:0] m_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      sat_r <= v >= tlpb_pkg::SAT_LIMIT;
      m_r   <= v[14:0] * tlpb_pkg::RECIP;
    end
    if (en.s4) begin
      q_r <= sat_r ? tlpb_pkg::CHANNEL_MAX
                   : m_r[tlpb_pkg::RECIP_SHIFT + 7 : tlpb_pkg::RECIP_SHIFT];
    end
  end

endmodule

`default_nettype wire

/* src/three_layer_pixel_blender_top.sv */
// Throughput: one pixel per cycle while out_tready is high; each stage loads
// when empty or when the stage after it moves, so bubbles close up while the
// output is held.
// Reset (synchronous, rst_n low): all stage valids clear, weights and mode to 0.
// ----------------------------------------------------------------------------
// three_layer_pixel_blender_top
// Three-layer RGB888 blender: weights, products, mode mix, /100, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module three_layer_pixel_blender_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: first_red, first_green, first_blue, second_red, second_green,
  //           second_blue, third_red, third_green, third_blue (8 bits each)
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,
  // out_tdata: out_red, out_green, out_blue (8 bits each)
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  tlpb_pkg::cfg_t     cfg_r;
  tlpb_pkg::reg_idx_t reg_idx;
  tlpb_pkg::pipe_en_t en;
  logic               wr_en;
  logic               v1_r, v2_r, v3_r, v4_r;

  // ---- configuration port
  assign cfg_pready = 1'b1;
  assign reg_idx    = tlpb_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        tlpb_pkg::REG_WEIGHT_FIRST:  cfg_r.weight_first  <= cfg_pwdata[6:0];
        tlpb_pkg::REG_WEIGHT_SECOND: cfg_r.weight_second <= cfg_pwdata[6:0];
        tlpb_pkg::REG_WEIGHT_THIRD:  cfg_r.weight_third  <= cfg_pwdata[6:0];
        tlpb_pkg::REG_BLEND_MODE:    cfg_r.blend_mode    <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlpb_pkg::REG_WEIGHT_FIRST:  cfg_prdata = {25'd0, cfg_r.weight_first};
      tlpb_pkg::REG_WEIGHT_SECOND: cfg_prdata = {25'd0, cfg_r.weight_second};
      tlpb_pkg::REG_WEIGHT_THIRD:  cfg_prdata = {25'd0, cfg_r.weight_third};
      tlpb_pkg::REG_BLEND_MODE:    cfg_prdata = {29'd0, cfg_r.blend_mode};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  // ---- pipeline control: a stage loads when empty or when its successor moves
  always_comb begin
    en.s4 = !v4_r || out_tready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_tready  = en.s1;
  assign out_tvalid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  // ---- datapath, one lane per colour channel
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [14:0]        t1, t2, t3;
    logic signed [17:0] xa, xb;
    logic [16:0]        v;

    tlpb_prod u_prod (
      .clk  (clk),
      .en   (en),
      .cfg  (cfg_r),
      .p1   (in_tdata[8*c +: 8]),
      .p2   (in_tdata[24 + 8*c +: 8]),
      .p3   (in_tdata[48 + 8*c +: 8]),
      .t1_r (t1),
      .t2_r (t2),
      .t3_r (t3),
      .xa_r (xa),
      .xb_r (xb)
    );

    tlpb_mix u_mix (
      .clk        (clk),
      .en         (en),
      .blend_mode (cfg_r.blend_mode),
      .t1         (t1),
      .t2         (t2),
      .t3         (t3),
      .xa         (xa),
      .xb         (xb),
      .v_r        (v)
    );

    tlpb_scale u_scale (
      .clk (clk),
      .en  (en),
      .v   (v),
      .q_r (out_tdata[8*c +: 8])
    );
  end

endmodule

`default_nettype wire

/* src/tlpb_checker.sv */
// ----------------------------------------------------------------------------
// tlpb_checker
// Port-level checks on the blender's stream behaviour, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // held result stays put until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a ready sink means every stage can move, so the input must be open
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with sink ready");

  // with the sink ready throughout, an accepted pixel reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) ##1 out_tready ##1 out_tready
      ##1 out_tready |=> out_tvalid)
    else $error("pixel not out after four cycles");

endmodule

bind three_layer_pixel_blender_top tlpb_checker u_tlpb_checker (.*);

`default_nettype wire
